// ===== sv/sols_pkg.sv =====
// Package for the self-organising list search block: shared constants,
// state and policy codes, and the result record.
// Depends on nothing; every other file imports it.
package sols_pkg;

  // Default sizes of the table, handed down by the top level.
  localparam int unsigned TABLE_DEPTH_DEF = 256;
  localparam int unsigned KEY_BITS_DEF    = 32;

  // Fixed widths of the channel fields.
  localparam int unsigned KEY_PORT_BITS = 32;
  localparam int unsigned VALUE_BITS    = 32;
  localparam int unsigned POS_BITS      = 8;

  // Operation codes carried in the mode field.
  localparam logic MODE_APPEND = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  // Reordering policy held in the configuration register.
  typedef enum logic {
    POLICY_MTF       = 1'b0,
    POLICY_TRANSPOSE = 1'b1
  } sols_policy_e;

  // Sequencer states, one-hot.
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_SHIFT = 5'b00100,
    ST_PLACE = 5'b01000,
    ST_FIN   = 5'b10000
  } sols_state_e;

  // One result item.
  typedef struct packed {
    logic                  hit;
    logic [VALUE_BITS-1:0] found_value;
    logic [POS_BITS-1:0]   found_position;
    logic                  table_full;
  } sols_result_t;

endpackage

// ===== sv/sols_if.sv =====
// Channel interfaces of the self-organising list search block: input items,
// result items and the configuration write channel.
// Depends on sols_pkg for the field widths.
interface sols_in_if import sols_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic [KEY_PORT_BITS-1:0] key;
  logic [VALUE_BITS-1:0]    value;

  modport source (output valid, mode, key, value, input ready);
  modport sink   (input valid, mode, key, value, output ready);
endinterface

interface sols_out_if import sols_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  hit;
  logic [VALUE_BITS-1:0] found_value;
  logic [POS_BITS-1:0]   found_position;
  logic                  table_full;

  modport source (output valid, hit, found_value, found_position, table_full,
                  input ready);
  modport sink   (input valid, hit, found_value, found_position, table_full,
                  output ready);
endinterface

interface sols_cfg_if ();
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== sv/self_organizing_list_search.sv =====
// Top level of the self-organising list search block: sequencer, count and
// policy registers, result register and the entry memory.
// Depends on sols_pkg, sols_if.sv and sols_mem.
//
//   Channel  Direction  Transfer carries
//   in_i     sink       mode, key, value
//   out_o    source     hit, found_value, found_position, table_full
//   cfg_i    sink       data (reorder policy)
//
// One item at a time. A search on an empty table skips the scan. The search
// time is set by the single read port of the entry memory, scanned one entry
// a cycle and then shifted one entry a cycle. Reset clears the entry count
// and the policy; the memory is not cleared. A new item is taken while the
// last result waits in the output register; a finished result waits in its
// final state until that register is free.
module self_organizing_list_search import sols_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int unsigned KEY_BITS    = KEY_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sols_in_if.sink   in_i,
  sols_out_if.source out_o,
  sols_cfg_if.sink  cfg_i
);

  localparam int unsigned SK = (KEY_BITS < KEY_PORT_BITS) ? KEY_BITS : KEY_PORT_BITS;
  localparam int unsigned IW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned EW = SK + VALUE_BITS;

  sols_state_e  state_q, state_d;
  sols_policy_e policy_q;
  logic [CW-1:0] count_q, count_d;
  logic [IW-1:0] ptr_q, ptr_d;
  logic [IW-1:0] stop_q, stop_d;
  logic [SK-1:0] skey_q, skey_d;
  logic [EW-1:0] ent_q, ent_d;
  sols_result_t  res_q, res_d;
  sols_result_t  out_q;
  logic          out_valid_q;
  logic          out_free;

  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;
  logic          mem_re;
  logic [IW-1:0] mem_raddr;
  logic [EW-1:0] mem_rdata;
  logic [SK-1:0] rd_key;
  logic [VALUE_BITS-1:0] rd_val;

  sols_mem #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (EW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign rd_key   = mem_rdata[EW-1:VALUE_BITS];
  assign rd_val   = mem_rdata[VALUE_BITS-1:0];
  assign out_free = !out_valid_q || out_o.ready;

  // Handshakes.
  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;

  assign out_o.valid          = out_valid_q;
  assign out_o.hit            = out_q.hit;
  assign out_o.found_value    = out_q.found_value;
  assign out_o.found_position = out_q.found_position;
  assign out_o.table_full     = out_q.table_full;

  // Sequencer: scan one entry a cycle, then shift entries back one a cycle
  // (the read of the next lower entry overlaps the write of the one above).
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    ptr_d     = ptr_q;
    stop_d    = stop_q;
    skey_d    = skey_q;
    ent_d     = ent_q;
    res_d     = res_q;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          res_d = '0;
          if (in_i.mode == MODE_APPEND) begin
            if (count_q == CW'(TABLE_DEPTH)) begin
              res_d.table_full = 1'b1;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = count_q[IW-1:0];
              mem_wdata = {in_i.key[SK-1:0], in_i.value};
              count_d   = count_q + CW'(1);
            end
            state_d = ST_FIN;
          end else begin
            skey_d = in_i.key[SK-1:0];
            if (count_q == '0) begin
              state_d = ST_FIN;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = '0;
              ptr_d     = '0;
              state_d   = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        if (rd_key == skey_q) begin
          res_d.hit            = 1'b1;
          res_d.found_value    = rd_val;
          res_d.found_position = POS_BITS'(ptr_q);
          ent_d                = mem_rdata;
          if (ptr_q == '0) begin
            state_d = ST_FIN;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = ptr_q - IW'(1);
            ptr_d     = ptr_q - IW'(1);
            stop_d    = (policy_q == POLICY_MTF) ? '0 : ptr_q - IW'(1);
            state_d   = ST_SHIFT;
          end
        end else if (CW'(ptr_q) == count_q - CW'(1)) begin
          state_d = ST_FIN;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = ptr_q + IW'(1);
          ptr_d     = ptr_q + IW'(1);
        end
      end
      ST_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_q + IW'(1);
        mem_wdata = mem_rdata;
        if (ptr_q == stop_q) begin
          state_d = ST_PLACE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = ptr_q - IW'(1);
          ptr_d     = ptr_q - IW'(1);
        end
      end
      ST_PLACE: begin
        // The found entry goes into the gap left by the shift.
        mem_we    = 1'b1;
        mem_waddr = stop_q;
        mem_wdata = ent_q;
        state_d   = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      policy_q    <= POLICY_MTF;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (cfg_i.valid) begin
        policy_q <= sols_policy_e'(cfg_i.data);
      end
      if (state_q == ST_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    ptr_q  <= ptr_d;
    stop_q <= stop_d;
    skey_q <= skey_d;
    ent_q  <= ent_d;
    res_q  <= res_d;
    if (state_q == ST_FIN && out_free) begin
      out_q <= res_q;
    end
  end

`ifndef SYNTHESIS
  // The entry count never passes the table depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(TABLE_DEPTH))
    else $error("entry count above table depth");

  // The scan only looks at occupied positions.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (CW'(ptr_q) < count_q))
    else $error("scan beyond occupied entries");

  // The shift never runs below its stopping position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SHIFT) |-> (ptr_q >= stop_q))
    else $error("shift pointer below stop position");

  // A read and a write never hit the same entry in one cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("memory read and write collide");
`endif

endmodule

// ===== sv/sols_mem.sv =====
// Entry memory of the self-organising list search block: one write port and
// one read port with registered read data.
// Depends on sols_pkg for the default sizes.
module sols_mem import sols_pkg::*; #(
  parameter int unsigned DEPTH = TABLE_DEPTH_DEF,
  parameter int unsigned WIDTH = KEY_PORT_BITS + VALUE_BITS,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port; the sequencer never reads and
  // writes the same entry in one cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== verif/tb.sv =====
// Testbench for the self-organising list search block: directed and random
// appends and searches under both reorder policies, checked against a table model.
// Depends on sols_pkg, the channel interfaces and self_organizing_list_search.
module tb;
  import sols_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH        = TABLE_DEPTH_DEF;
  localparam int          HOLD_CYCLES  = 3000;
  localparam int          IDLE_LIMIT   = 40000;
  localparam int          DRAIN_CYCLES = 2 * DEPTH + 16;
  localparam int          REPORT_MAX   = 10;

  logic clk_i;
  logic rst_ni;

  sols_in_if  in_if ();
  sols_out_if out_if ();
  sols_cfg_if cfg_if ();

  self_organizing_list_search #(
    .TABLE_DEPTH (TABLE_DEPTH_DEF),
    .KEY_BITS    (KEY_BITS_DEF)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // Shadow copy of the table and the policy register.
  logic [KEY_PORT_BITS-1:0] shadow_keys [DEPTH];
  logic [VALUE_BITS-1:0]    shadow_values [DEPTH];
  int unsigned              shadow_count;
  sols_policy_e             shadow_policy;

  sols_result_t pending_results [$];
  int           mismatches;
  int           idle_cycles;
  int           burst_left;
  bit           no_gaps;
  bit           hold_request;

  // Keys that recur, so that duplicates and the extremes turn up often.
  logic [KEY_PORT_BITS-1:0] key_pool [6] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0001,
                                             32'h7FFF_FFFE, 32'h1234_5678, 32'hA5A5_5A5A};

  // Clock.
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Expected result of one transfer, with the shadow table updated as the block would.
  function automatic sols_result_t predict_table_access(logic m, logic [KEY_PORT_BITS-1:0] k,
                                                        logic [VALUE_BITS-1:0] v);
    sols_result_t             r;
    int unsigned              pos;
    logic [KEY_PORT_BITS-1:0] fk;
    logic [VALUE_BITS-1:0]    fv;
    r = '0;
    if (m == MODE_APPEND) begin
      if (shadow_count >= DEPTH) begin
        r.table_full = 1'b1;
      end else begin
        shadow_keys[shadow_count]   = k;
        shadow_values[shadow_count] = v;
        shadow_count++;
      end
      return r;
    end
    pos = 0;
    while (pos < shadow_count && shadow_keys[pos] != k) pos++;
    if (pos < shadow_count) begin
      fk = shadow_keys[pos];
      fv = shadow_values[pos];
      r.hit            = 1'b1;
      r.found_value    = fv;
      r.found_position = pos[POS_BITS-1:0];
      if (pos > 0) begin
        if (shadow_policy == POLICY_MTF) begin
          for (int unsigned i = pos; i > 0; i--) begin
            shadow_keys[i]   = shadow_keys[i-1];
            shadow_values[i] = shadow_values[i-1];
          end
          shadow_keys[0]   = fk;
          shadow_values[0] = fv;
        end else begin
          shadow_keys[pos]     = shadow_keys[pos-1];
          shadow_values[pos]   = shadow_values[pos-1];
          shadow_keys[pos-1]   = fk;
          shadow_values[pos-1] = fv;
        end
      end
    end
    return r;
  endfunction

  // Random word with the extremes mixed in.
  function automatic logic [31:0] random_word();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // Offer one item, with bursts and gaps, and record its expected result on transfer.
  task automatic send_item(input logic m, input logic [KEY_PORT_BITS-1:0] k,
                           input logic [VALUE_BITS-1:0] v);
    int gap;
    @(negedge clk_i);
    if (!no_gaps) begin
      if (burst_left == 0) begin
        gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        burst_left = $urandom_range(1, 30);
        if (gap > 0) begin
          in_if.valid <= 1'b0;
          repeat (gap) @(negedge clk_i);
        end
      end
      burst_left--;
    end
    in_if.valid <= 1'b1;
    in_if.mode  <= m;
    in_if.key   <= k;
    in_if.value <= v;
    do @(posedge clk_i); while (!in_if.ready);
    pending_results.push_back(predict_table_access(m, k, v));
  endtask

  // Drop the input valid and wait until every result has been taken.
  task automatic wait_until_idle();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    wait (pending_results.size() == 0);
  endtask

  // Write the policy register while the block is idle.
  task automatic write_policy(input sols_policy_e p);
    wait_until_idle();
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= p;
    do @(posedge clk_i); while (!cfg_if.ready);
    shadow_policy = p;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Extremes of the fields and the special cases, starting from the reset policy.
  task automatic directed_test();
    send_item(MODE_SEARCH, 32'h0000_0000, 32'hFFFF_FFFF);   // search on an empty table
    send_item(MODE_APPEND, 32'h0000_0000, 32'hFFFF_FFFF);
    send_item(MODE_APPEND, 32'hFFFF_FFFF, 32'h0000_0000);
    send_item(MODE_APPEND, 32'h1234_5678, 32'hA5A5_A5A5);
    send_item(MODE_APPEND, 32'h1234_5678, 32'h5A5A_5A5A);   // duplicate key
    send_item(MODE_APPEND, 32'h8000_0000, 32'h8000_0001);
    send_item(MODE_SEARCH, 32'h0000_0000, 32'h0000_0000);   // hit at the front
    send_item(MODE_SEARCH, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(MODE_SEARCH, 32'h1234_5678, 32'h0000_0000);   // front-most duplicate
    send_item(MODE_SEARCH, 32'h8000_0000, 32'h0000_0000);
    send_item(MODE_SEARCH, 32'hDEAD_BEEF, 32'h0000_0000);   // absent key
    write_policy(POLICY_TRANSPOSE);
    send_item(MODE_SEARCH, 32'h8000_0000, 32'hFFFF_FFFF);   // hit at the front
    send_item(MODE_SEARCH, 32'h0000_0000, 32'h0000_0000);
    send_item(MODE_SEARCH, 32'h1234_5678, 32'h0000_0000);
    send_item(MODE_SEARCH, 32'h0000_0000, 32'h0000_0000);
    send_item(MODE_SEARCH, 32'hFFFF_FFFE, 32'h0000_0000);   // absent key
    send_item(MODE_APPEND, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_item(MODE_SEARCH, 32'h7FFF_FFFF, 32'h0000_0000);   // hit at the tail
  endtask

  // Random mix of appends and searches, most searches for keys that are present.
  task automatic random_test(input int count, input sols_policy_e p, input int append_pct);
    logic [KEY_PORT_BITS-1:0] k;
    int unsigned              idx;
    int                       pick;
    write_policy(p);
    repeat (count) begin
      if ($urandom_range(0, 99) < append_pct) begin
        k = ($urandom_range(0, 4) == 0) ? key_pool[$urandom_range(0, 5)] : $urandom();
        send_item(MODE_APPEND, k, random_word());
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 65 && shadow_count > 0) begin
          if ($urandom_range(0, 3) == 0)
            idx = $urandom_range(0, shadow_count - 1);
          else
            idx = $urandom_range(0, (shadow_count > 16) ? 15 : shadow_count - 1);
          k = shadow_keys[idx];
        end else if (pick < 75) begin
          k = key_pool[$urandom_range(0, 5)];
        end else begin
          k = $urandom();
        end
        send_item(MODE_SEARCH, k, random_word());
      end
    end
  endtask

  // Receiver holds off for a long stretch while items keep coming, so the input stalls.
  task automatic pressure_test();
    wait_until_idle();
    hold_request = 1'b1;
    no_gaps      = 1'b1;
    for (int i = 0; i < 12; i++) begin
      if (i % 3 == 0 || shadow_count == 0)
        send_item(MODE_APPEND, $urandom(), $urandom());
      else
        send_item(MODE_SEARCH, shadow_keys[$urandom_range(0, (shadow_count > 8) ? 7 :
                                                        shadow_count - 1)], $urandom());
    end
    no_gaps = 1'b0;
  endtask

  // Fill the table to the last position, then appends that must be refused.
  task automatic fill_test();
    while (shadow_count < DEPTH) send_item(MODE_APPEND, $urandom(), random_word());
    repeat (3) send_item(MODE_APPEND, random_word(), random_word());
  endtask

  // Receiver: a stall pattern of its own that changes now and then, plus the long hold-off.
  initial begin : receiver
    logic [15:0] stall_pattern;
    int          epoch_left;
    int          hold_left;
    int          step;
    out_if.ready <= 1'b0;
    stall_pattern = 16'hFFFF;
    epoch_left    = 0;
    hold_left     = 0;
    step          = 0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (epoch_left == 0) begin
        epoch_left    = $urandom_range(16, 128);
        stall_pattern = ($urandom_range(0, 2) == 0) ? 16'hFFFF : $urandom();
      end
      epoch_left--;
      step = (step + 1) % 16;
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= stall_pattern[step];
      end
    end
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk_i) begin
    sols_result_t got;
    sols_result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.hit            = out_if.hit;
      got.found_value    = out_if.found_value;
      got.found_position = out_if.found_position;
      got.table_full     = out_if.table_full;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected result: hit=%0b value=%h pos=%0d full=%0b",
                   got.hit, got.found_value, got.found_position, got.table_full);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("mismatch: expected hit/value/pos/full %0b %h %0d %0b, got %0b %h %0d %0b",
                     want.hit, want.found_value, want.found_position, want.table_full,
                     got.hit, got.found_value, got.found_position, got.table_full);
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Main sequence.
  initial begin
    in_if.valid   <= 1'b0;
    in_if.mode    <= MODE_APPEND;
    in_if.key     <= '0;
    in_if.value   <= '0;
    cfg_if.valid  <= 1'b0;
    cfg_if.data   <= POLICY_MTF;
    rst_ni        <= 1'b0;
    shadow_count  = 0;
    shadow_policy = POLICY_MTF;
    mismatches    = 0;
    idle_cycles   = 0;
    burst_left    = 0;
    no_gaps       = 1'b0;
    hold_request  = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    directed_test();
    random_test(400, POLICY_MTF, 45);
    pressure_test();
    random_test(400, POLICY_TRANSPOSE, 25);
    fill_test();
    random_test(370, POLICY_MTF, 10);

    wait_until_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== self_organizing_list_search.f =====
sv/sols_pkg.sv
sv/sols_if.sv
sv/sols_mem.sv
sv/self_organizing_list_search.sv
verif/tb.sv
